### design/mlrq_pkg.sv
// Package for the multilevel ready queue scheduler.
// Holds payload structs, op and class codes, register indexes and limits.
// No dependencies.
package mlrq_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_PICK   = 2'd1,
      OP_TICK   = 2'd2,
      OP_AGE    = 2'd3
   } op_type;

   localparam logic [1:0] CLASS_BOTTOM = 2'd0;
   localparam logic [1:0] CLASS_MIDDLE = 2'd1;
   localparam logic [1:0] CLASS_TOP    = 2'd2;

   localparam logic [2:0] REG_LOW_LIMIT  = 3'd0;
   localparam logic [2:0] REG_HIGH_LIMIT = 3'd1;
   localparam logic [2:0] REG_WAIT_STEP  = 3'd2;
   localparam logic [2:0] REG_AGE_LIMIT  = 3'd3;
   localparam logic [2:0] REG_BOOST      = 3'd4;

   localparam logic [7:0] PRIO_MAX = 8'd149;

   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  thread_id;
      logic [7:0]  thread_priority;
      logic [15:0] thread_burst;
      logic [15:0] running_burst;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  picked_id;
      logic        preempt;
      logic [4:0]  promoted_count;
   } rsp_type;

   // entry record as held in the thread table memory
   typedef struct packed {
      logic [1:0]  cls;
      logic [7:0]  prio;
      logic [15:0] sort_key;
      logic [15:0] wait_cnt;
      logic [15:0] arrival;
      logic [15:0] burst;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CHK,
      ST_SCAN,
      ST_CLOSE,
      ST_WRITE,
      ST_AGE_NEXT,
      ST_DONE
   } state_type;

endpackage

### design/multilevel_ready_queue_scheduler.sv
// Multilevel ready queue scheduler: three-class ready queue over a thread table.
// Insert reads the entry and, if already queued, closes its rank gap before the write;
// an id outside the table is ignored. Pick scans for the head, then closes its gap; age
// runs one pass, then a search, gap close and requeue per promotion. Each pass reads one
// entry per cycle. One command at a time; the next is accepted from the result cycle on.
// Reset clears queued flags and arrival counter and loads default settings; the receiver cannot stall.
module multilevel_ready_queue_scheduler #(
   parameter int MAX_THREADS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  mlrq_pkg::req_type   req_data,
   output logic                rsp_valid,
   output mlrq_pkg::rsp_type   rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_wdata
);
   localparam int IW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int CW = $clog2(MAX_THREADS + 1);

   // control and working registers
   mlrq_pkg::state_type state_ff, state_in;
   logic [MAX_THREADS-1:0] queued_ff, queued_in;
   logic [MAX_THREADS-1:0] sel_ff, sel_in;      // aging candidates
   logic [15:0]    arr_cnt_ff, arr_cnt_in;
   mlrq_pkg::req_type req_ff, req_in;
   logic [CW-1:0]  idx_ff, idx_in;              // read pointer
   logic [IW-1:0]  wptr_ff, wptr_in;            // entry held in rd_data_ff
   logic           rvalid_ff, rvalid_in;
   logic           best_ok_ff, best_ok_in;
   logic [IW-1:0]  best_id_ff, best_id_in;
   mlrq_pkg::entry_type best_ff, best_in;
   logic [15:0]    gap_ff, gap_in;              // rank being closed
   logic [IW-1:0]  tgt_ff, tgt_in;              // entry written after closing
   logic [1:0]     age_cls_ff, age_cls_in;      // class being requeued
   logic           age_srch_ff, age_srch_in;    // age past its first pass
   logic [4:0]     promo_ff, promo_in;
   logic           rsp_valid_ff, rsp_valid_in;
   mlrq_pkg::rsp_type rsp_ff, rsp_in;

   // configuration registers
   logic [7:0]  low_lim_ff, high_lim_ff, boost_ff;
   logic [11:0] step_ff;
   logic [15:0] age_lim_ff;

   assign csr_ready = (state_ff == mlrq_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         low_lim_ff  <= 8'd50;
         high_lim_ff <= 8'd100;
         step_ff     <= 12'd100;
         age_lim_ff  <= 16'd1500;
         boost_ff    <= 8'd10;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mlrq_pkg::REG_LOW_LIMIT:  low_lim_ff  <= csr_wdata[7:0];
            mlrq_pkg::REG_HIGH_LIMIT: high_lim_ff <= csr_wdata[7:0];
            mlrq_pkg::REG_WAIT_STEP:  step_ff     <= csr_wdata[11:0];
            mlrq_pkg::REG_AGE_LIMIT:  age_lim_ff  <= csr_wdata;
            mlrq_pkg::REG_BOOST:      boost_ff    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   function automatic logic [1:0] class_of(input logic [7:0] p, input logic [7:0] lo,
                                           input logic [7:0] hi);
      if (p >= hi) return mlrq_pkg::CLASS_TOP;
      if (p >= lo) return mlrq_pkg::CLASS_MIDDLE;
      return mlrq_pkg::CLASS_BOTTOM;
   endfunction

   // thread table memory, one read and one write port
   mlrq_pkg::entry_type mem [MAX_THREADS];
   mlrq_pkg::entry_type rd_data_ff;
   logic [IW-1:0]       rd_addr, wr_addr;
   logic                wr_en;
   mlrq_pkg::entry_type wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   logic [IW-1:0] cur;
   logic [IW-1:0] req_id;
   logic          id_ok;
   logic [7:0]    ins_prio;
   logic          better;
   logic          hit;
   logic [16:0]   wsum;
   logic [8:0]    psum;
   logic [7:0]    pnew;
   logic          scan_last;

   assign cur       = idx_ff[IW-1:0];
   assign req_id    = IW'(req_ff.thread_id);
   assign id_ok     = ({28'd0, req_ff.thread_id} < 32'(MAX_THREADS));
   assign ins_prio  = (req_ff.thread_priority > mlrq_pkg::PRIO_MAX) ?
                      mlrq_pkg::PRIO_MAX : req_ff.thread_priority;
   assign scan_last = (idx_ff == CW'(MAX_THREADS));
   assign hit       = rvalid_ff && queued_ff[wptr_ff];
   assign wsum      = {1'b0, rd_data_ff.wait_cnt} + {5'd0, step_ff};
   assign psum      = {1'b0, rd_data_ff.prio} + {1'b0, boost_ff};
   assign pnew      = (psum > {1'b0, mlrq_pkg::PRIO_MAX}) ? mlrq_pkg::PRIO_MAX : psum[7:0];
   assign busy      = (state_ff != mlrq_pkg::ST_IDLE);

   // ordering of the candidate in rd_data_ff against the best so far
   always_comb begin
      better = 1'b0;
      if (!best_ok_ff || rd_data_ff.cls > best_ff.cls) begin
         better = 1'b1;
      end else if (rd_data_ff.cls == best_ff.cls) begin
         if (rd_data_ff.cls == mlrq_pkg::CLASS_TOP && rd_data_ff.sort_key != best_ff.sort_key)
            better = rd_data_ff.sort_key < best_ff.sort_key;
         else if (rd_data_ff.cls == mlrq_pkg::CLASS_MIDDLE &&
                  rd_data_ff.sort_key != best_ff.sort_key)
            better = rd_data_ff.sort_key > best_ff.sort_key;
         else
            better = rd_data_ff.arrival < best_ff.arrival;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mlrq_pkg::ST_IDLE:
            if (start) begin
               state_in = (req_data.op == mlrq_pkg::OP_INSERT) ? mlrq_pkg::ST_INS_RD
                                                                : mlrq_pkg::ST_SCAN;
            end
         mlrq_pkg::ST_INS_RD:
            state_in = id_ok ? mlrq_pkg::ST_INS_CHK : mlrq_pkg::ST_DONE;
         mlrq_pkg::ST_INS_CHK:
            state_in = queued_ff[tgt_ff] ? mlrq_pkg::ST_CLOSE : mlrq_pkg::ST_WRITE;
         mlrq_pkg::ST_SCAN:
            if (scan_last) begin
               if (req_ff.op == mlrq_pkg::OP_PICK)
                  state_in = best_ok_in ? mlrq_pkg::ST_CLOSE : mlrq_pkg::ST_DONE;
               else if (req_ff.op == mlrq_pkg::OP_AGE) begin
                  if (age_srch_ff && best_ok_in)
                     state_in = mlrq_pkg::ST_CLOSE;
                  else if (!age_srch_ff || age_cls_ff == mlrq_pkg::CLASS_MIDDLE)
                     state_in = mlrq_pkg::ST_AGE_NEXT;
                  else
                     state_in = mlrq_pkg::ST_DONE;
               end else
                  state_in = mlrq_pkg::ST_DONE;
            end
         mlrq_pkg::ST_CLOSE:
            if (scan_last) begin
               state_in = (req_ff.op == mlrq_pkg::OP_PICK) ? mlrq_pkg::ST_DONE
                                                            : mlrq_pkg::ST_WRITE;
            end
         mlrq_pkg::ST_WRITE:
            state_in = (req_ff.op == mlrq_pkg::OP_AGE) ? mlrq_pkg::ST_AGE_NEXT
                                                        : mlrq_pkg::ST_DONE;
         mlrq_pkg::ST_AGE_NEXT:
            state_in = (sel_ff == '0) ? mlrq_pkg::ST_DONE : mlrq_pkg::ST_SCAN;
         mlrq_pkg::ST_DONE:     state_in = mlrq_pkg::ST_IDLE;
         default:               state_in = mlrq_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      queued_in    = queued_ff;
      sel_in       = sel_ff;
      arr_cnt_in   = arr_cnt_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      wptr_in      = wptr_ff;
      rvalid_in    = 1'b0;
      best_ok_in   = best_ok_ff;
      best_id_in   = best_id_ff;
      best_in      = best_ff;
      gap_in       = gap_ff;
      tgt_in       = tgt_ff;
      age_cls_in   = age_cls_ff;
      age_srch_in  = age_srch_ff;
      promo_in     = promo_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_addr      = cur;
      wr_en        = 1'b0;
      wr_addr      = wptr_ff;
      wr_data      = rd_data_ff;

      unique case (state_ff)
         mlrq_pkg::ST_IDLE: begin
            if (start) begin
               req_in      = req_data;
               idx_in      = '0;
               best_ok_in  = 1'b0;
               promo_in    = '0;
               sel_in      = '0;
               age_cls_in  = mlrq_pkg::CLASS_MIDDLE;
               age_srch_in = 1'b0;
               rsp_in      = '0;
            end
         end
         mlrq_pkg::ST_INS_RD: begin
            // fetch the old arrival rank of the entry being replaced
            rd_addr = req_id;
            tgt_in  = req_id;
         end
         mlrq_pkg::ST_INS_CHK: begin
            // already queued: remove first and close its rank gap
            if (queued_ff[tgt_ff]) begin
               gap_in            = rd_data_ff.arrival;
               queued_in[tgt_ff] = 1'b0;
               if (arr_cnt_ff != 16'd0) arr_cnt_in = arr_cnt_ff - 16'd1;
               idx_in            = '0;
            end
         end
         mlrq_pkg::ST_SCAN: begin
            if (!scan_last) begin
               rd_addr   = cur;
               wptr_in   = cur;
               idx_in    = idx_ff + CW'(1);
               rvalid_in = 1'b1;
            end
            if (hit) begin
               case (req_ff.op)
                  mlrq_pkg::OP_PICK: begin
                     if (better) begin
                        best_ok_in = 1'b1;
                        best_id_in = wptr_ff;
                        best_in    = rd_data_ff;
                     end
                  end
                  mlrq_pkg::OP_TICK: begin
                     wr_en            = 1'b1;
                     wr_data.wait_cnt = wsum[16] ? 16'hFFFF : wsum[15:0];
                  end
                  mlrq_pkg::OP_AGE: begin
                     if (!age_srch_ff) begin
                        // first pass: age expired entries, mark promotions
                        if (rd_data_ff.wait_cnt >= age_lim_ff) begin
                           wr_en            = 1'b1;
                           wr_data.wait_cnt = 16'd0;
                           wr_data.prio     = pnew;
                           if (class_of(pnew, low_lim_ff, high_lim_ff) > rd_data_ff.cls)
                              sel_in[wptr_ff] = 1'b1;
                        end
                     end else if (sel_ff[wptr_ff] && rd_data_ff.cls == age_cls_ff &&
                                  better) begin
                        best_ok_in = 1'b1;
                        best_id_in = wptr_ff;
                        best_in    = rd_data_ff;
                     end
                  end
                  default: ;
               endcase
            end
            // end of pass: take the head out, or move on to the bottom class
            if (scan_last) begin
               if (req_ff.op == mlrq_pkg::OP_PICK && best_ok_in) begin
                  rsp_in.found          = 1'b1;
                  rsp_in.picked_id      = 4'(best_id_in);
                  tgt_in                = best_id_in;
                  gap_in                = best_in.arrival;
                  queued_in[best_id_in] = 1'b0;
                  if (arr_cnt_ff != 16'd0) arr_cnt_in = arr_cnt_ff - 16'd1;
                  idx_in                = '0;
               end
               if (req_ff.op == mlrq_pkg::OP_AGE && age_srch_ff) begin
                  if (best_ok_in) begin
                     sel_in[best_id_in]    = 1'b0;
                     tgt_in                = best_id_in;
                     gap_in                = best_in.arrival;
                     queued_in[best_id_in] = 1'b0;
                     if (arr_cnt_ff != 16'd0) arr_cnt_in = arr_cnt_ff - 16'd1;
                     idx_in                = '0;
                  end else if (age_cls_ff == mlrq_pkg::CLASS_MIDDLE) begin
                     age_cls_in = mlrq_pkg::CLASS_BOTTOM;
                  end
               end
            end
         end
         mlrq_pkg::ST_CLOSE: begin
            if (!scan_last) begin
               rd_addr   = cur;
               wptr_in   = cur;
               idx_in    = idx_ff + CW'(1);
               rvalid_in = 1'b1;
            end
            if (hit && rd_data_ff.arrival > gap_ff) begin
               wr_en           = 1'b1;
               wr_data.arrival = rd_data_ff.arrival - 16'd1;
            end
         end
         mlrq_pkg::ST_WRITE: begin
            // queue the entry at the tail rank with a fresh sort key
            wr_en   = 1'b1;
            wr_addr = tgt_ff;
            if (req_ff.op == mlrq_pkg::OP_INSERT) begin
               wr_data.prio     = ins_prio;
               wr_data.burst    = req_ff.thread_burst;
               wr_data.wait_cnt = 16'd0;
            end else begin
               wr_data = best_ff;
               if (promo_ff != 5'd31) promo_in = promo_ff + 5'd1;
            end
            wr_data.cls      = class_of(wr_data.prio, low_lim_ff, high_lim_ff);
            wr_data.sort_key = (wr_data.cls == mlrq_pkg::CLASS_TOP) ? wr_data.burst :
                               (wr_data.cls == mlrq_pkg::CLASS_MIDDLE) ?
                               {8'd0, wr_data.prio} : 16'd0;
            wr_data.arrival  = arr_cnt_ff;
            arr_cnt_in       = arr_cnt_ff + 16'd1;
            queued_in[tgt_ff] = 1'b1;
            if (req_ff.op == mlrq_pkg::OP_INSERT)
               rsp_in.preempt = (wr_data.cls == mlrq_pkg::CLASS_TOP) &&
                                (req_ff.thread_burst < req_ff.running_burst);
         end
         mlrq_pkg::ST_AGE_NEXT: begin
            // search the current class for the next candidate head
            idx_in      = '0;
            best_ok_in  = 1'b0;
            age_srch_in = 1'b1;
         end
         mlrq_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            if (req_ff.op == mlrq_pkg::OP_AGE) rsp_in.promoted_count = promo_ff;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlrq_pkg::ST_IDLE;
         queued_ff    <= '0;
         arr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         rvalid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         queued_ff    <= queued_in;
         arr_cnt_ff   <= arr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rvalid_ff    <= rvalid_in;
      end
   end

   // working registers, set up at each command transfer
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      wptr_ff     <= wptr_in;
      best_ok_ff  <= best_ok_in;
      best_id_ff  <= best_id_in;
      best_ff     <= best_in;
      gap_ff      <= gap_in;
      tgt_ff      <= tgt_in;
      sel_ff      <= sel_in;
      age_cls_ff  <= age_cls_in;
      age_srch_ff <= age_srch_in;
      promo_ff    <= promo_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### sim/tb_multilevel_ready_queue_scheduler.sv
// Testbench for the multilevel ready queue scheduler.
// Drives insert/pick/tick/age commands and register writes, predicts each result.
// Depends on mlrq_pkg and multilevel_ready_queue_scheduler.

// Holds the predicted ready queue state and the results still awaited
class sched_scoreboard;
   mlrq_pkg::rsp_type awaited_q[$];
   int                fail_count;
   logic [7:0]        low_limit, high_limit, boost;
   logic [11:0]       wait_step;
   logic [15:0]       age_limit;
   bit                queued[16];
   logic [1:0]        cls[16];
   logic [7:0]        prio[16];
   logic [15:0]       sort_key[16];
   logic [15:0]       wait_cnt[16];
   logic [15:0]       arrival[16];
   logic [15:0]       burst[16];
   logic [15:0]       next_rank;

   function new();
      fail_count = 0;
      low_limit  = 8'd50;
      high_limit = 8'd100;
      wait_step  = 12'd100;
      age_limit  = 16'd1500;
      boost      = 8'd10;
      next_rank  = '0;
      foreach (queued[i]) queued[i] = 1'b0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
         mlrq_pkg::REG_LOW_LIMIT:  low_limit  = data[7:0];
         mlrq_pkg::REG_HIGH_LIMIT: high_limit = data[7:0];
         mlrq_pkg::REG_WAIT_STEP:  wait_step  = data[11:0];
         mlrq_pkg::REG_AGE_LIMIT:  age_limit  = data;
         mlrq_pkg::REG_BOOST:      boost      = data[7:0];
         default: ;
      endcase
   endfunction

   function logic [1:0] class_for(logic [7:0] p);
      if (p >= high_limit) return mlrq_pkg::CLASS_TOP;
      if (p >= low_limit) return mlrq_pkg::CLASS_MIDDLE;
      return mlrq_pkg::CLASS_BOTTOM;
   endfunction

   function void join_queue(int i);
      cls[i] = class_for(prio[i]);
      if (cls[i] == mlrq_pkg::CLASS_TOP) sort_key[i] = burst[i];
      else if (cls[i] == mlrq_pkg::CLASS_MIDDLE) sort_key[i] = {8'd0, prio[i]};
      else sort_key[i] = '0;
      arrival[i] = next_rank;
      next_rank++;
      queued[i] = 1'b1;
   endfunction

   // removing closes the gap in arrival ranks
   function void leave_queue(int i);
      queued[i] = 1'b0;
      for (int j = 0; j < 16; j++)
         if (queued[j] && arrival[j] > arrival[i]) arrival[j]--;
      if (next_rank > 0) next_rank--;
   endfunction

   function bit ahead_of(int a, int b, logic [1:0] c);
      if (c != mlrq_pkg::CLASS_BOTTOM && sort_key[a] != sort_key[b])
         return (c == mlrq_pkg::CLASS_TOP) ? sort_key[a] < sort_key[b]
                                           : sort_key[a] > sort_key[b];
      return arrival[a] < arrival[b];
   endfunction

   function int head_of(logic [1:0] c, bit chosen[16]);
      int best;
      best = -1;
      for (int i = 0; i < 16; i++)
         if (queued[i] && chosen[i] && cls[i] == c)
            if (best < 0 || ahead_of(i, best, c)) best = i;
      return best;
   endfunction

   // note an accepted command and queue its predicted result
   function void note_command(mlrq_pkg::req_type r);
      mlrq_pkg::rsp_type res;
      bit                chosen[16];
      int                h, id;
      logic [8:0]        p;
      logic [16:0]       w;
      res = '0;
      case (mlrq_pkg::op_type'(r.op))
         mlrq_pkg::OP_INSERT: begin
            id = r.thread_id;
            if (queued[id]) leave_queue(id);
            prio[id] = (r.thread_priority > mlrq_pkg::PRIO_MAX) ? mlrq_pkg::PRIO_MAX
                                                                : r.thread_priority;
            burst[id] = r.thread_burst;
            wait_cnt[id] = '0;
            join_queue(id);
            res.preempt = (cls[id] == mlrq_pkg::CLASS_TOP) &&
                          (r.thread_burst < r.running_burst);
         end
         mlrq_pkg::OP_PICK: begin
            foreach (chosen[i]) chosen[i] = 1'b1;
            h = head_of(mlrq_pkg::CLASS_TOP, chosen);
            if (h < 0) h = head_of(mlrq_pkg::CLASS_MIDDLE, chosen);
            if (h < 0) h = head_of(mlrq_pkg::CLASS_BOTTOM, chosen);
            if (h >= 0) begin
               leave_queue(h);
               res.found = 1'b1;
               res.picked_id = h[3:0];
            end
         end
         mlrq_pkg::OP_TICK: begin
            for (int i = 0; i < 16; i++)
               if (queued[i]) begin
                  w = wait_cnt[i] + wait_step;
                  wait_cnt[i] = w[16] ? 16'hFFFF : w[15:0];
               end
         end
         default: begin
            for (int i = 0; i < 16; i++) begin
               chosen[i] = 1'b0;
               if (queued[i] && wait_cnt[i] >= age_limit) begin
                  wait_cnt[i] = '0;
                  p = prio[i] + boost;
                  if (p > mlrq_pkg::PRIO_MAX) p = mlrq_pkg::PRIO_MAX;
                  prio[i] = p[7:0];
                  if (class_for(prio[i]) > cls[i]) chosen[i] = 1'b1;
               end
            end
            // middle class first, then bottom, each in queue order
            for (int c = 1; c >= 0; c--)
               forever begin
                  h = head_of(c[1:0], chosen);
                  if (h < 0) break;
                  chosen[h] = 1'b0;
                  leave_queue(h);
                  join_queue(h);
                  if (res.promoted_count < 5'd31) res.promoted_count++;
               end
         end
      endcase
      awaited_q.push_back(res);
   endfunction

   function void check_result(mlrq_pkg::rsp_type got, longint t);
      mlrq_pkg::rsp_type exp;
      if (awaited_q.size() == 0) begin
         $display("%0t: unexpected result %p", t, got);
         fail_count++;
         return;
      end
      exp = awaited_q.pop_front();
      if (got.found !== exp.found || got.picked_id !== exp.picked_id ||
          got.preempt !== exp.preempt || got.promoted_count !== exp.promoted_count) begin
         $display("%0t: result mismatch expected %p actual %p", t, exp, got);
         fail_count++;
      end
   endfunction
endclass

module tb_multilevel_ready_queue_scheduler;

   localparam longint CYCLE_LIMIT = 3000000;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   mlrq_pkg::req_type req_data;
   logic              rsp_valid;
   mlrq_pkg::rsp_type rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [2:0]        csr_index;
   logic [15:0]       csr_wdata;
   longint            cycle_count;

   sched_scoreboard board;

   multilevel_ready_queue_scheduler u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // result checking and cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) board.check_result(rsp_data, $time);
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL multilevel_ready_queue_scheduler");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // one command transfer; start stays high when the next follows at once
   task automatic send_command(mlrq_pkg::req_type r);
      int g;
      req_data <= r;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_command(r);
      g = gap_len();
      if (g != 0) begin
         start <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (board.awaited_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic mlrq_pkg::req_type make_cmd(mlrq_pkg::op_type op, int id, int p,
                                                  int b, int run);
      mlrq_pkg::req_type r;
      r.op = op;
      r.thread_id = id[3:0];
      r.thread_priority = p[7:0];
      r.thread_burst = b[15:0];
      r.running_burst = run[15:0];
      return r;
   endfunction

   // random command mix weighted toward inserts and picks
   function automatic mlrq_pkg::req_type random_cmd();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)
         return make_cmd(mlrq_pkg::OP_INSERT, $urandom_range(0, 15),
                         ($urandom_range(0, 9) == 0) ? $urandom_range(150, 255)
                                                     : $urandom_range(0, 149),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                     : $urandom_range(0, 60),
                         $urandom_range(0, 65535));
      if (r < 65) return make_cmd(mlrq_pkg::OP_PICK, $urandom_range(0, 15), $urandom,
                                  $urandom, $urandom);
      if (r < 85) return make_cmd(mlrq_pkg::OP_TICK, $urandom_range(0, 15), $urandom,
                                  $urandom, $urandom);
      return make_cmd(mlrq_pkg::OP_AGE, $urandom_range(0, 15), $urandom, $urandom,
                      $urandom);
   endfunction

   task automatic random_phase(int n);
      for (int k = 0; k < n; k++) send_command(random_cmd());
   endtask

   initial begin
      board       = new();
      cycle_count = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_valid   = 1'b0;
      csr_index   = mlrq_pkg::REG_LOW_LIMIT;
      csr_wdata   = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty pick, extremes, reinsert, tie order, aging
      send_command(make_cmd(mlrq_pkg::OP_PICK, 0, 0, 0, 0));
      send_command(make_cmd(mlrq_pkg::OP_AGE, 0, 0, 0, 0));
      send_command(make_cmd(mlrq_pkg::OP_INSERT, 15, 255, 0, 65535));
      send_command(make_cmd(mlrq_pkg::OP_INSERT, 0, 0, 65535, 0));
      send_command(make_cmd(mlrq_pkg::OP_INSERT, 3, 100, 500, 500));
      send_command(make_cmd(mlrq_pkg::OP_INSERT, 4, 100, 500, 501));
      send_command(make_cmd(mlrq_pkg::OP_INSERT, 5, 99, 9, 9));
      send_command(make_cmd(mlrq_pkg::OP_INSERT, 6, 50, 7, 7));
      send_command(make_cmd(mlrq_pkg::OP_INSERT, 7, 49, 1, 1));
      send_command(make_cmd(mlrq_pkg::OP_INSERT, 3, 149, 1, 2));
      send_command(make_cmd(mlrq_pkg::OP_INSERT, 8, 45, 0, 0));
      for (int k = 0; k < 16; k++) send_command(make_cmd(mlrq_pkg::OP_TICK, 0, 0, 0, 0));
      send_command(make_cmd(mlrq_pkg::OP_AGE, 0, 0, 0, 0));
      for (int k = 0; k < 9; k++) send_command(make_cmd(mlrq_pkg::OP_PICK, 0, 0, 0, 0));
      wait_drained();

      // wait saturation and mass promotion with extreme settings
      write_reg(mlrq_pkg::REG_WAIT_STEP, 16'h0FFF);
      write_reg(mlrq_pkg::REG_AGE_LIMIT, 16'hFFFF);
      write_reg(mlrq_pkg::REG_BOOST, 16'd149);
      for (int k = 0; k < 16; k++) send_command(make_cmd(mlrq_pkg::OP_INSERT, k, k, k, 0));
      for (int k = 0; k < 17; k++) send_command(make_cmd(mlrq_pkg::OP_TICK, 0, 0, 0, 0));
      send_command(make_cmd(mlrq_pkg::OP_AGE, 0, 0, 0, 0));
      wait_drained();

      // default-like settings, frequent aging
      write_reg(mlrq_pkg::REG_LOW_LIMIT, 16'd40);
      write_reg(mlrq_pkg::REG_HIGH_LIMIT, 16'd90);
      write_reg(mlrq_pkg::REG_WAIT_STEP, 16'd300);
      write_reg(mlrq_pkg::REG_AGE_LIMIT, 16'd600);
      write_reg(mlrq_pkg::REG_BOOST, 16'd25);
      random_phase(180);
      wait_drained();

      // crossed limits, zero step and zero age limit
      write_reg(mlrq_pkg::REG_LOW_LIMIT, 16'd149);
      write_reg(mlrq_pkg::REG_HIGH_LIMIT, 16'd0);
      write_reg(mlrq_pkg::REG_WAIT_STEP, 16'd0);
      write_reg(mlrq_pkg::REG_AGE_LIMIT, 16'd0);
      write_reg(mlrq_pkg::REG_BOOST, 16'd0);
      random_phase(80);
      wait_drained();

      // wide limits, large step, small boost
      write_reg(mlrq_pkg::REG_LOW_LIMIT, 16'd0);
      write_reg(mlrq_pkg::REG_HIGH_LIMIT, 16'd149);
      write_reg(mlrq_pkg::REG_WAIT_STEP, 16'd2000);
      write_reg(mlrq_pkg::REG_AGE_LIMIT, 16'd4000);
      write_reg(mlrq_pkg::REG_BOOST, 16'd7);
      random_phase(110);
      wait_drained();

      write_reg(mlrq_pkg::REG_LOW_LIMIT, 16'd30);
      write_reg(mlrq_pkg::REG_HIGH_LIMIT, 16'd60);
      write_reg(mlrq_pkg::REG_WAIT_STEP, 16'd500);
      write_reg(mlrq_pkg::REG_AGE_LIMIT, 16'd1000);
      write_reg(mlrq_pkg::REG_BOOST, 16'd15);
      random_phase(130);

      wait_drained();
      if (board.fail_count == 0 && board.awaited_q.size() == 0) begin
         $display("PASS multilevel_ready_queue_scheduler");
      end else begin
         $display("FAIL multilevel_ready_queue_scheduler");
      end
      $finish;
   end

endmodule
